[hdl/rfsr_pkg.sv]
// ---------------------------------------------------------------------------
// rfsr_pkg
// Shared types, constants and codes of the register frame slave responder.
// ---------------------------------------------------------------------------
`default_nettype none

package rfsr_pkg;

  // Frame store depth and derived widths
  localparam int FRAME_BYTES = 32;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int COUNT_W     = $clog2(FRAME_BYTES + 1);

  // Bytes fetched from the frame store for decoding (header plus two data words)
  localparam int HDR_BYTES   = 11;
  localparam int HDR_IDX_W   = $clog2(HDR_BYTES + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_CODE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CODE    = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0] SLAVE_ADDRESS_RST = 8'd1;
  localparam logic [6:0] READ_CODE_RST     = 7'd3;
  localparam logic [6:0] WRITE_CODE_RST    = 7'd16;

  // Exception codes
  localparam logic [7:0] ERR_FUNC  = 8'd1;
  localparam logic [7:0] ERR_ADDR  = 8'd2;
  localparam logic [7:0] ERR_VALUE = 8'd3;

  // Response constants
  localparam logic [7:0]  ERR_FLAG    = 8'h80;
  localparam logic [15:0] CRC_FILLER  = 16'h1234;

  // Request item
  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic        low_pressure;
    logic [30:0] keys;
    logic [7:0]  level_value;
    logic        system_on;
    logic        cut_wire;
    logic        low_water;
  } req_t;

  // Response item
  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [15:0] hold_word0;
    logic [15:0] hold_word1;
  } rsp_t;

  // Kind of response decided for a frame
  typedef enum logic [1:0] {
    RESP_NONE,
    RESP_ERR,
    RESP_READ,
    RESP_WRITE
  } resp_kind_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_SEND
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic store;        // request byte transfer this cycle
    logic begin_frame;  // that byte closes the frame
    logic fetch;        // step the frame store read sweep
    logic eval;         // decode the fetched frame
    logic advance;      // response byte transfer this cycle
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic frame_end;    // frame end flag of the offered request byte
    logic fetch_done;   // last header byte is captured this cycle
    logic has_reply;    // decoded frame gives a response
    logic last;         // current response byte is the final one
  } status_t;

endpackage

`default_nettype wire

[hdl/rfsr_ram.sv]
// ---------------------------------------------------------------------------
// rfsr_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rfsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/rfsr_ctrl.sv]
// ---------------------------------------------------------------------------
// rfsr_ctrl
// Frame sequencer: collects bytes, sweeps the frame store, decodes, sends.
// ---------------------------------------------------------------------------
`default_nettype none

module rfsr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire rfsr_pkg::status_t status,
  output rfsr_pkg::cmd_t         cmd
);

  rfsr_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfsr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rfsr_pkg::ST_IDLE: begin
        if (in_valid && status.frame_end) begin
          state_next = rfsr_pkg::ST_FETCH;
        end
      end
      rfsr_pkg::ST_FETCH: begin
        if (status.fetch_done) begin
          state_next = rfsr_pkg::ST_EVAL;
        end
      end
      rfsr_pkg::ST_EVAL: begin
        state_next = status.has_reply ? rfsr_pkg::ST_SEND : rfsr_pkg::ST_IDLE;
      end
      rfsr_pkg::ST_SEND: begin
        if (out_ready && status.last) begin
          state_next = rfsr_pkg::ST_IDLE;
        end
      end
      default: state_next = rfsr_pkg::ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    cmd             = '0;
    unique case (state)
      rfsr_pkg::ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.store       = in_valid;
        cmd.begin_frame = in_valid && status.frame_end;
      end
      rfsr_pkg::ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      rfsr_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      rfsr_pkg::ST_SEND: begin
        out_valid   = 1'b1;
        cmd.advance = out_ready;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[hdl/rfsr_datapath.sv]
// ---------------------------------------------------------------------------
// rfsr_datapath
// Frame store, header capture, request checks, holding words and response
// byte generation.
// ---------------------------------------------------------------------------
`default_nettype none

module rfsr_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire rfsr_pkg::req_t                      in_data,
  output rfsr_pkg::rsp_t                           out_data,
  input  wire logic                                cfg_we,
  input  wire logic [rfsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [7:0]                          cfg_data,
  input  wire rfsr_pkg::cmd_t                      cmd,
  output rfsr_pkg::status_t                        status
);

  // Configuration
  logic [7:0] slave_address;
  logic [6:0] read_code;
  logic [6:0] write_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= rfsr_pkg::SLAVE_ADDRESS_RST;
      read_code     <= rfsr_pkg::READ_CODE_RST;
      write_code    <= rfsr_pkg::WRITE_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rfsr_pkg::CFG_SLAVE_ADDRESS: slave_address <= cfg_data;
        rfsr_pkg::CFG_READ_CODE:     read_code     <= cfg_data[6:0];
        rfsr_pkg::CFG_WRITE_CODE:    write_code    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Frame fill count; bytes past the store depth are dropped
  logic [rfsr_pkg::COUNT_W-1:0] count;
  logic [rfsr_pkg::COUNT_W-1:0] count_next;
  logic [rfsr_pkg::COUNT_W-1:0] n_q;
  logic                         room;

  assign room       = count < rfsr_pkg::COUNT_W'(rfsr_pkg::FRAME_BYTES);
  assign count_next = room ? count + 1'b1 : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.store) begin
      count <= cmd.begin_frame ? '0 : count_next;
    end
  end

  // Frame length and status inputs are latched with the frame end byte
  logic [15:0] words [3];

  always_ff @(posedge clk) begin
    if (cmd.begin_frame) begin
      n_q      <= count_next;
      words[0] <= {in_data.keys[14:0], in_data.low_pressure};
      words[1] <= in_data.keys[30:15];
      words[2] <= {4'b0000, in_data.low_water, in_data.cut_wire, 1'b1,
                   in_data.system_on, in_data.level_value};
    end
  end

  // Frame store
  logic [rfsr_pkg::HDR_IDX_W-1:0] fidx;
  logic [7:0]                     ram_rdata;

  rfsr_ram #(
    .WIDTH (8),
    .DEPTH (rfsr_pkg::FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store && room),
    .waddr (count[rfsr_pkg::ADDR_W-1:0]),
    .wdata (in_data.rx_byte),
    .raddr (rfsr_pkg::ADDR_W'(fidx)),
    .rdata (ram_rdata)
  );

  // Read sweep over the header bytes; the registered read data arrives in the cycle after its address
  logic [7:0] hdr [rfsr_pkg::HDR_BYTES];

  always_ff @(posedge clk) begin
    if (rst) begin
      fidx <= '0;
    end else if (cmd.begin_frame) begin
      fidx <= '0;
    end else if (cmd.fetch) begin
      fidx <= fidx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch && fidx != '0) begin
      hdr[fidx - 1'b1] <= ram_rdata;
    end
  end

  assign status.fetch_done =
    cmd.fetch && (fidx == rfsr_pkg::HDR_IDX_W'(rfsr_pkg::HDR_BYTES));

  // Request checks
  logic [15:0] start_w;
  logic [15:0] cnt_w;
  logic [16:0] span;
  logic [9:0]  need;
  logic        is_write;
  logic        is_read;
  logic        frame_ok;
  rfsr_pkg::resp_kind_t kind_d;
  logic [7:0]  err_d;
  logic        wr_ok;

  assign start_w  = {hdr[2], hdr[3]};
  assign cnt_w    = {hdr[4], hdr[5]};
  assign span     = {1'b0, start_w} + {1'b0, cnt_w};
  assign need     = {2'b00, hdr[6]} + 10'd9;
  assign is_write = hdr[1] == {1'b0, write_code};
  assign is_read  = hdr[1] == {1'b0, read_code};
  assign frame_ok = (n_q >= rfsr_pkg::COUNT_W'(6)) && (hdr[0] == slave_address);

  always_comb begin
    kind_d = rfsr_pkg::RESP_NONE;
    err_d  = rfsr_pkg::ERR_FUNC;
    wr_ok  = 1'b0;
    priority if (!frame_ok) begin
      kind_d = rfsr_pkg::RESP_NONE;
    end else if (is_write) begin
      priority if (n_q < rfsr_pkg::COUNT_W'(7)) begin
        kind_d = rfsr_pkg::RESP_NONE;
      end else if (start_w > 16'd1 || span > 17'd2) begin
        kind_d = rfsr_pkg::RESP_ERR;
        err_d  = rfsr_pkg::ERR_ADDR;
      end else if (cnt_w == 16'd0 || {9'b0, hdr[6]} != {cnt_w, 1'b0}
                   || need > 10'(n_q)) begin
        kind_d = rfsr_pkg::RESP_ERR;
        err_d  = rfsr_pkg::ERR_VALUE;
      end else begin
        kind_d = rfsr_pkg::RESP_WRITE;
        wr_ok  = 1'b1;
      end
    end else if (is_read) begin
      priority if (start_w > 16'd2 || span > 17'd3) begin
        kind_d = rfsr_pkg::RESP_ERR;
        err_d  = rfsr_pkg::ERR_ADDR;
      end else if (cnt_w == 16'd0) begin
        kind_d = rfsr_pkg::RESP_ERR;
        err_d  = rfsr_pkg::ERR_VALUE;
      end else begin
        kind_d = rfsr_pkg::RESP_READ;
      end
    end else begin
      kind_d = rfsr_pkg::RESP_ERR;
      err_d  = rfsr_pkg::ERR_FUNC;
    end
  end

  assign status.has_reply = kind_d != rfsr_pkg::RESP_NONE;

  // Decoded response held for the send phase
  rfsr_pkg::resp_kind_t kind;
  logic [7:0] err_q;
  logic [1:0] start_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= rfsr_pkg::RESP_NONE;
    end else if (cmd.eval) begin
      kind <= kind_d;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      err_q   <= err_d;
      start_q <= start_w[1:0];
      cnt_q   <= cnt_w[1:0];
    end
  end

  // Holding words: one or two big-endian words after the byte count
  logic [15:0] hold0;
  logic [15:0] hold1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold0 <= '0;
      hold1 <= '0;
    end else if (cmd.eval && wr_ok) begin
      if (start_w[0]) begin
        hold1 <= {hdr[7], hdr[8]};
      end else begin
        hold0 <= {hdr[7], hdr[8]};
        if (cnt_w[1]) begin
          hold1 <= {hdr[9], hdr[10]};
        end
      end
    end
  end

  // Response byte index
  logic [3:0] k;

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.eval) begin
      k <= '0;
    end else if (cmd.advance) begin
      k <= k + 1'b1;
    end
  end

  // Response byte selection
  logic [3:0]  len;
  logic [3:0]  j;
  logic [3:0]  wbytes;
  logic [1:0]  widx;
  logic [15:0] wsel;
  logic [7:0]  byte_d;

  assign j      = k - 4'd3;
  assign wbytes = {1'b0, cnt_q, 1'b0};
  assign widx   = start_q + j[2:1];

  always_comb begin
    case (widx)
      2'd0:    wsel = words[0];
      2'd1:    wsel = words[1];
      default: wsel = words[2];
    endcase
  end

  always_comb begin
    len    = 4'd3;
    byte_d = slave_address;
    unique case (kind)
      rfsr_pkg::RESP_WRITE: begin
        len = 4'd8;
        unique case (k)
          4'd0:    byte_d = slave_address;
          4'd1:    byte_d = {1'b0, write_code};
          4'd2:    byte_d = hdr[2];
          4'd3:    byte_d = hdr[3];
          4'd4:    byte_d = hdr[4];
          4'd5:    byte_d = hdr[5];
          4'd6:    byte_d = rfsr_pkg::CRC_FILLER[15:8];
          default: byte_d = rfsr_pkg::CRC_FILLER[7:0];
        endcase
      end
      rfsr_pkg::RESP_READ: begin
        len = wbytes + 4'd5;
        priority if (k == 4'd0) begin
          byte_d = slave_address;
        end else if (k == 4'd1) begin
          byte_d = {1'b0, read_code};
        end else if (k == 4'd2) begin
          byte_d = {4'b0000, wbytes};
        end else if (j < wbytes) begin
          byte_d = j[0] ? wsel[15:8] : wsel[7:0];
        end else if (j == wbytes) begin
          byte_d = rfsr_pkg::CRC_FILLER[15:8];
        end else begin
          byte_d = rfsr_pkg::CRC_FILLER[7:0];
        end
      end
      default: begin
        // exception reply: address, code with error flag, exception code
        len = 4'd3;
        unique case (k)
          4'd0:    byte_d = slave_address;
          4'd1:    byte_d = hdr[1] | rfsr_pkg::ERR_FLAG;
          default: byte_d = err_q;
        endcase
      end
    endcase
  end

  assign status.last      = k == (len - 4'd1);
  assign status.frame_end = in_data.frame_end;

  assign out_data.tx_byte    = byte_d;
  assign out_data.tx_last    = status.last;
  assign out_data.hold_word0 = hold0;
  assign out_data.hold_word1 = hold1;

endmodule

`default_nettype wire

[hdl/register_frame_slave_responder_top.sv]
// ---------------------------------------------------------------------------
// register_frame_slave_responder_top
// Slave responder for register read / write request frames.
// ---------------------------------------------------------------------------
// Request bytes are taken one per cycle into a frame store until a byte
// marked frame_end. That byte starts decoding: eleven header and data bytes
// are swept out of the frame store through its single registered read port,
// an evaluation state decides the reply, then each response byte (3 to 11
// of them) is offered until taken. No request byte is accepted while a frame
// end is being handled; other bytes are taken as they come. The frame store
// needs no clearing pass after reset. Configuration is to be written only
// between frames; a write takes effect at once.
`default_nettype none

module register_frame_slave_responder_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire rfsr_pkg::req_t                 in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output rfsr_pkg::rsp_t                      out_data,
  input  wire logic                           cfg_we,
  input  wire logic [rfsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data
);

  rfsr_pkg::cmd_t    cmd;
  rfsr_pkg::status_t status;

  // Sequencer
  rfsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath
  rfsr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

[test/rfsr_response_checker.sv]
// ---------------------------------------------------------------------------
// rfsr_response_checker
// Watches the request, response and configuration ports of the register
// frame slave responder, works out every response byte each accepted request
// byte should cause, and compares the response transfers against them in
// order. Mismatches and the number of bytes still due go back to the bench.
// ---------------------------------------------------------------------------
module rfsr_response_checker
  import rfsr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire req_t                 in_data,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire rsp_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  output int                        mismatches,
  output int                        outstanding
);

  // Own copy of the frame store, holding words and settings
  logic [7:0]  frame_bytes [FRAME_BYTES];
  int unsigned byte_count;
  logic [15:0] hold_words [2];
  logic [7:0]  station;
  logic [6:0]  rd_code;
  logic [6:0]  wr_code;

  // Response bytes still to come, oldest first
  rsp_t due_bytes [$];

  // Decode the collected frame and queue the response it earns
  task automatic decode_frame(req_t item);
    logic [7:0]  reply [$];
    logic [7:0]  code;
    logic [7:0]  nbytes;
    logic [31:0] start;
    logic [31:0] count;
    logic [15:0] words [3];
    rsp_t        r;
    int unsigned k;
    if (byte_count >= 6 && frame_bytes[0] == station) begin
      code  = frame_bytes[1];
      start = {16'd0, frame_bytes[2], frame_bytes[3]};
      count = {16'd0, frame_bytes[4], frame_bytes[5]};
      if (code == {1'b0, wr_code}) begin
        // write multiple; a bare header earns nothing
        if (byte_count >= 7) begin
          nbytes = frame_bytes[6];
          if (start > 1 || start + count > 2) begin
            reply = '{station, code | ERR_FLAG, ERR_ADDR};
          end else if (count == 0 || nbytes != 2 * count || 9 + nbytes > byte_count) begin
            reply = '{station, code | ERR_FLAG, ERR_VALUE};
          end else begin
            // data words arrive high byte first
            for (k = 0; k < count; k++) begin
              hold_words[(start + k) & 1] = {frame_bytes[7 + 2 * k], frame_bytes[8 + 2 * k]};
            end
            reply = '{station, code, start[15:8], start[7:0], count[15:8], count[7:0],
                      CRC_FILLER[15:8], CRC_FILLER[7:0]};
          end
        end
      end else if (code == {1'b0, rd_code}) begin
        if (start > 2 || start + count > 3) begin
          reply = '{station, code | ERR_FLAG, ERR_ADDR};
        end else if (count == 0) begin
          reply = '{station, code | ERR_FLAG, ERR_VALUE};
        end else begin
          // status words as sampled with the frame end byte
          words[0] = {item.keys[14:0], item.low_pressure};
          words[1] = item.keys[30:15];
          words[2] = {4'd0, item.low_water, item.cut_wire, 1'b1, item.system_on,
                      item.level_value};
          reply = '{station, code, 8'(2 * count)};
          for (k = 0; k < count; k++) begin
            reply.push_back(words[start + k][7:0]);
            reply.push_back(words[start + k][15:8]);
          end
          reply.push_back(CRC_FILLER[15:8]);
          reply.push_back(CRC_FILLER[7:0]);
        end
      end else begin
        reply = '{station, code | ERR_FLAG, ERR_FUNC};
      end
    end
    for (k = 0; k < reply.size(); k++) begin
      r.tx_byte    = reply[k];
      r.tx_last    = (k == reply.size() - 1);
      r.hold_word0 = hold_words[0];
      r.hold_word1 = hold_words[1];
      due_bytes.push_back(r);
    end
  endtask

  // One request byte: store it while there is room, decode on frame end
  task automatic take_byte(req_t item);
    if (byte_count < FRAME_BYTES) begin
      frame_bytes[byte_count] = item.rx_byte;
      byte_count++;
    end
    if (item.frame_end) begin
      decode_frame(item);
      byte_count = 0;
    end
  endtask

  // Compare one response transfer with the oldest byte due
  task automatic check_reply(rsp_t got);
    rsp_t want;
    if (due_bytes.size() == 0) begin
      $error("response transfer with nothing due: tx_byte %02h tx_last %0b",
             got.tx_byte, got.tx_last);
      mismatches++;
    end else begin
      want = due_bytes.pop_front();
      if (got.tx_byte !== want.tx_byte) begin
        $error("tx_byte: expected %02h, got %02h", want.tx_byte, got.tx_byte);
        mismatches++;
      end
      if (got.tx_last !== want.tx_last) begin
        $error("tx_last: expected %0b, got %0b", want.tx_last, got.tx_last);
        mismatches++;
      end
      if (got.hold_word0 !== want.hold_word0) begin
        $error("hold_word0: expected %04h, got %04h", want.hold_word0, got.hold_word0);
        mismatches++;
      end
      if (got.hold_word1 !== want.hold_word1) begin
        $error("hold_word1: expected %04h, got %04h", want.hold_word1, got.hold_word1);
        mismatches++;
      end
    end
  endtask

  // Sample all ports on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      byte_count    = 0;
      hold_words[0] = '0;
      hold_words[1] = '0;
      station       = SLAVE_ADDRESS_RST;
      rd_code       = READ_CODE_RST;
      wr_code       = WRITE_CODE_RST;
      mismatches    = 0;
      due_bytes.delete();
    end else begin
      if (out_valid && out_ready) check_reply(out_data);
      if (in_valid && in_ready) take_byte(in_data);
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLAVE_ADDRESS: station = cfg_data;
          CFG_READ_CODE:     rd_code = cfg_data[6:0];
          CFG_WRITE_CODE:    wr_code = cfg_data[6:0];
          default: ;
        endcase
      end
    end
    outstanding <= due_bytes.size();
  end

endmodule

[test/tb_register_frame_slave_responder_top.sv]
// ---------------------------------------------------------------------------
// tb_register_frame_slave_responder_top
// Drives request frames and settings into the register frame slave responder.
// A short directed set covers reads, writes, every error and the frames that
// earn no reply; random frames follow under several settings, with random
// idling on both sides, one long response hold-off and a quiet final stretch.
// The response checker beside the block supplies the verdict inputs.
// ---------------------------------------------------------------------------
module tb_register_frame_slave_responder_top;
  import rfsr_pkg::*;

  localparam int LONG_HOLD    = 400;   // response hold-off to back the block up
  localparam int DRAIN_CYCLES = 30;    // covers a frame end that earns no reply
  localparam int QUIET_LIMIT  = 3000;  // cycles without any transfer

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  req_t                 in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  rsp_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SLAVE_ADDRESS;
  logic [7:0]           cfg_data  = '0;

  int mismatches;
  int outstanding;
  int sent_items   = 0;
  int quiet_cycles = 0;
  bit calm         = 1'b0;
  bit hold_req     = 1'b0;
  bit holding      = 1'b0;

  // Settings as last written
  logic [7:0] cur_addr = SLAVE_ADDRESS_RST;
  logic [6:0] cur_rc   = READ_CODE_RST;
  logic [6:0] cur_wc   = WRITE_CODE_RST;

  // Bytes of the frame being built
  logic [7:0] frame_q [$];

  register_frame_slave_responder_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rfsr_response_checker resp_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog: too long without any transfer means the block has hung
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Response side: random stalls, one long hold-off on request, none when calm
  initial begin : sink
    wait (!rst);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        holding = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        holding  = 1'b0;
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  function automatic req_t random_status();
    req_t s;
    s              = '0;
    s.low_pressure = 1'($urandom);
    s.keys         = 31'($urandom);
    s.level_value  = 8'($urandom);
    s.system_on    = 1'($urandom);
    s.cut_wire     = 1'($urandom);
    s.low_water    = 1'($urandom);
    return s;
  endfunction

  // Offer one request byte and hold it until the transfer, then maybe idle
  task automatic send_item(req_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Send the built frame; the closing byte carries the given status inputs
  task automatic send_frame(req_t closing);
    req_t item;
    int   k;
    for (k = 0; k < frame_q.size(); k++) begin
      item           = (k == frame_q.size() - 1) ? closing : random_status();
      item.rx_byte   = frame_q[k];
      item.frame_end = (k == frame_q.size() - 1);
      send_item(item);
    end
    frame_q.delete();
  endtask

  task automatic push_header(logic [7:0] addr, logic [7:0] code, logic [15:0] start,
                             logic [15:0] count);
    frame_q.push_back(addr);
    frame_q.push_back(code);
    frame_q.push_back(start[15:8]);
    frame_q.push_back(start[7:0]);
    frame_q.push_back(count[15:8]);
    frame_q.push_back(count[7:0]);
  endtask

  // Byte count field followed by random data bytes
  task automatic push_data(logic [7:0] nbytes, int unsigned ndata);
    frame_q.push_back(nbytes);
    repeat (ndata) frame_q.push_back(8'($urandom));
  endtask

  // Checksum bytes are not checked by the block, so any value will do
  task automatic push_crc();
    repeat (2) frame_q.push_back(8'($urandom));
  endtask

  // Sender stops, waits for every response and for a silent frame end to finish
  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] addr, logic [6:0] rc, logic [6:0] wc);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLAVE_ADDRESS;
    cfg_data  <= addr;
    @(posedge clk);
    cfg_index <= CFG_READ_CODE;
    cfg_data  <= {1'b0, rc};
    @(posedge clk);
    cfg_index <= CFG_WRITE_CODE;
    cfg_data  <= {1'b0, wc};
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_addr = addr;
    cur_rc   = rc;
    cur_wc   = wc;
  endtask

  // Mostly well-formed requests, the rest errors, foreign, short or noise
  task automatic random_frame();
    int unsigned kind;
    int unsigned len;
    int unsigned k;
    logic [15:0] start;
    logic [15:0] count;
    logic [7:0]  code;
    logic [7:0]  first;
    kind  = $urandom_range(0, 99);
    code  = $urandom_range(0, 1) ? {1'b0, cur_rc} : {1'b0, cur_wc};
    first = $urandom_range(0, 1) ? cur_addr : 8'($urandom);
    if (kind < 40) begin
      start = 16'($urandom_range(0, 2));
      count = 16'($urandom_range(1, 3 - start));
      push_header(cur_addr, {1'b0, cur_rc}, start, count);
    end else if (kind < 70) begin
      start = 16'($urandom_range(0, 1));
      count = 16'($urandom_range(1, 2 - start));
      push_header(cur_addr, {1'b0, cur_wc}, start, count);
      push_data(8'(2 * count), 2 * count);
    end else if (kind < 78) begin
      // register range, often far out
      start = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3));
      count = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3));
      push_header(cur_addr, code, start, count);
      push_data(8'(2 * count), $urandom_range(0, 4));
    end else if (kind < 84) begin
      // byte count or data length at odds with the word count
      count = 16'($urandom_range(0, 2));
      push_header(cur_addr, {1'b0, cur_wc}, 16'd0, count);
      push_data(8'($urandom_range(0, 5)), $urandom_range(0, 4));
    end else if (kind < 89) begin
      push_header(cur_addr, 8'($urandom), 16'($urandom_range(0, 2)),
                  16'($urandom_range(0, 3)));
    end else if (kind < 93) begin
      push_header(cur_addr + 8'($urandom_range(1, 255)), code, 16'd0, 16'd1);
    end else begin
      // short or overlong noise
      len = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      for (k = 0; k < len; k++) begin
        frame_q.push_back(k == 0 ? first : (k == 1 ? code : 8'($urandom)));
      end
    end
    if (kind < 93) push_crc();
    send_frame(random_status());
  endtask

  task automatic run_random(int n);
    int target;
    target = sent_items + n;
    while (sent_items < target) random_frame();
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    logic [6:0] rc;
    wait (!rst);
    @(posedge clk);

    // all three status words, every status bit set
    push_header(cur_addr, {1'b0, cur_rc}, 16'd0, 16'd3);
    send_frame('1);
    // level word alone, every status bit clear
    push_header(cur_addr, {1'b0, cur_rc}, 16'd2, 16'd1);
    send_frame('0);
    // both holding words, extreme data
    push_header(cur_addr, {1'b0, cur_wc}, 16'd0, 16'd2);
    frame_q.push_back(8'd4);
    frame_q.push_back(8'hff);
    frame_q.push_back(8'hff);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'h00);
    push_crc();
    send_frame(random_status());
    // one word into holding word 1
    push_header(cur_addr, {1'b0, cur_wc}, 16'd1, 16'd1);
    push_data(8'd2, 2);
    push_crc();
    send_frame(random_status());
    // start and count at their maximum: range error
    push_header(cur_addr, {1'b0, cur_rc}, 16'hffff, 16'hffff);
    send_frame(random_status());
    // read of no words: count error
    push_header(cur_addr, {1'b0, cur_rc}, 16'd0, 16'd0);
    send_frame(random_status());
    // byte count disagrees with the word count
    push_header(cur_addr, {1'b0, cur_wc}, 16'd0, 16'd2);
    push_data(8'd3, 3);
    push_crc();
    send_frame(random_status());
    // write cut short before its data ends
    push_header(cur_addr, {1'b0, cur_wc}, 16'd0, 16'd2);
    push_data(8'd4, 2);
    push_crc();
    send_frame(random_status());
    // unknown code with the top bit already set
    push_header(cur_addr, 8'hff, 16'd0, 16'd1);
    send_frame(random_status());
    // another station
    push_header(cur_addr + 8'd1, {1'b0, cur_rc}, 16'd0, 16'd1);
    send_frame(random_status());
    // shorter than a header
    push_header(cur_addr, {1'b0, cur_rc}, 16'd0, 16'd1);
    void'(frame_q.pop_back());
    send_frame(random_status());
    // write with nothing past the header
    push_header(cur_addr, {1'b0, cur_wc}, 16'd0, 16'd1);
    send_frame(random_status());
    // overlong: only the first stored bytes are decoded
    push_header(cur_addr, {1'b0, cur_rc}, 16'd0, 16'd3);
    repeat (27) frame_q.push_back(8'($urandom));
    send_frame(random_status());
    settle();

    // top address, extreme codes; long response hold-off while a read reply
    // waits and more requests are offered, then a full drain
    set_config(8'hff, 7'h7f, 7'h00);
    hold_req = 1'b1;
    wait (holding);
    push_header(cur_addr, {1'b0, cur_rc}, 16'd0, 16'd3);
    push_crc();
    send_frame(random_status());
    run_random(8);
    settle();

    // bottom address, codes swapped round
    set_config(8'h00, 7'h00, 7'h7f);
    run_random(6);
    settle();

    // both codes equal: every request with that code decodes as a write
    rc = 7'($urandom);
    set_config(8'($urandom), rc, rc);
    run_random(6);
    settle();

    // final stretch with no idling on either side
    calm = 1'b1;
    rc   = 7'($urandom);
    set_config(8'($urandom), rc, rc ^ 7'($urandom_range(1, 127)));
    run_random(10);
    settle();

    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/rfsr_pkg.sv
hdl/rfsr_ram.sv
hdl/rfsr_ctrl.sv
hdl/rfsr_datapath.sv
hdl/register_frame_slave_responder_top.sv
test/rfsr_response_checker.sv
test/tb_register_frame_slave_responder_top.sv
